[hdl/eeg_pkg.sv]
// Shared types for the extended Euclid GCD block.
package eeg_pkg;

	// Control from the sequencer to the shared divide unit
	typedef struct packed {
		logic load;   // start a new division: latch dividend, clear remainder and products
		logic run;    // do one restoring step
	} div_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_UPDATE = 4'b1000
	} seq_state_t;

endpackage

[hdl/eeg_if.sv]
// Request and result channel interfaces for the extended Euclid GCD block.
interface eeg_in_if #(
	parameter int OPERAND_WIDTH = 32
);
	logic                     valid;
	logic                     ready;
	logic [OPERAND_WIDTH-1:0] first_value;
	logic [OPERAND_WIDTH-1:0] second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface eeg_out_if #(
	parameter int OPERAND_WIDTH = 32
);
	logic                        valid;
	logic                        ready;
	logic signed [OPERAND_WIDTH:0] coefficient_a;
	logic signed [OPERAND_WIDTH:0] coefficient_b;
	logic [OPERAND_WIDTH-1:0]    greatest_divisor;

	modport source (output valid, output coefficient_a, output coefficient_b,
		output greatest_divisor, input ready);
	modport sink   (input valid, input coefficient_a, input coefficient_b,
		input greatest_divisor, output ready);
endinterface

[hdl/eeg_div_unit.sv]
// Shared bit-serial divider: restoring division with quotient-times-coefficient accumulation.
module eeg_div_unit import eeg_pkg::*; #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                     clk,
	input  div_ctrl_t                ctrl,
	input  logic [OPERAND_WIDTH-1:0] dividend,
	input  logic [OPERAND_WIDTH-1:0] divisor,
	input  logic [OPERAND_WIDTH:0]   coef_x,
	input  logic [OPERAND_WIDTH:0]   coef_y,
	output logic [OPERAND_WIDTH-1:0] rem,
	output logic [OPERAND_WIDTH:0]   prod_x,
	output logic [OPERAND_WIDTH:0]   prod_y
);

	logic [OPERAND_WIDTH-1:0] dividend_q;
	logic [OPERAND_WIDTH-1:0] rem_q;
	logic [OPERAND_WIDTH:0]   prod_x_q;
	logic [OPERAND_WIDTH:0]   prod_y_q;

	logic [OPERAND_WIDTH:0]   trial;
	logic [OPERAND_WIDTH:0]   diff;
	logic                     qbit;

	always_comb begin
		trial = {rem_q, dividend_q[OPERAND_WIDTH-1]};
		diff  = trial - {1'b0, divisor};
		qbit  = (trial >= {1'b0, divisor});
	end

	// Products accumulate Horner-style as quotient bits arrive MSB first,
	// all modulo 2^(OPERAND_WIDTH+1)
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dividend_q <= dividend;
			rem_q      <= '0;
			prod_x_q   <= '0;
			prod_y_q   <= '0;
		end else if (ctrl.run) begin
			dividend_q <= {dividend_q[OPERAND_WIDTH-2:0], 1'b0};
			rem_q      <= qbit ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
			prod_x_q   <= {prod_x_q[OPERAND_WIDTH-1:0], 1'b0} + (qbit ? coef_x : '0);
			prod_y_q   <= {prod_y_q[OPERAND_WIDTH-1:0], 1'b0} + (qbit ? coef_y : '0);
		end
	end

	assign rem    = rem_q;
	assign prod_x = prod_x_q;
	assign prod_y = prod_y_q;

endmodule

[hdl/extended_euclid_gcd.sv]
// Extended Euclid GCD: gcd(a, b) with Bezout coefficients x, y such that a*x + b*y = g.
// One request at a time. After a request is accepted the block runs the remainder
// sequence; each Euclid step is one full division done by a shared restoring divider
// at one quotient bit per cycle, going through the states check, divide and coefficient
// update. When the remainder reaches zero after k division steps, the result is
// registered and the block returns to idle with it, ready for the next request; k is 0
// when the first operand is zero and grows roughly with the log of the operands (up to
// 46 for 32-bit operands). The result sits in an output register, so a waiting result
// does not block the next request from being accepted and computed; the block only
// stalls when a new result is done while the previous one has not been taken.
// If a is zero the result is g = b, x = 0, y = 1; if b is zero, g = a, x = 1, y = 0.
module extended_euclid_gcd import eeg_pkg::*; #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	eeg_in_if.sink   operands,
	eeg_out_if.source result
);

	localparam int CW = $clog2(OPERAND_WIDTH);
	localparam logic [CW-1:0] LAST_BIT = CW'(OPERAND_WIDTH - 1);

	seq_state_t               state_q;
	logic [CW-1:0]            cnt_q;
	logic [OPERAND_WIDTH-1:0] g_q;
	logic [OPERAND_WIDTH-1:0] a_q;
	logic [OPERAND_WIDTH:0]   cx_q;
	logic [OPERAND_WIDTH:0]   cy_q;
	logic [OPERAND_WIDTH:0]   nx_q;
	logic [OPERAND_WIDTH:0]   ny_q;

	logic                     out_valid_q;
	logic [OPERAND_WIDTH:0]   out_x_q;
	logic [OPERAND_WIDTH:0]   out_y_q;
	logic [OPERAND_WIDTH-1:0] out_g_q;

	div_ctrl_t                div_ctrl;
	logic [OPERAND_WIDTH-1:0] div_rem;
	logic [OPERAND_WIDTH:0]   div_prod_x;
	logic [OPERAND_WIDTH:0]   div_prod_y;

	logic accept;
	logic out_free;
	logic finish;

	assign accept   = operands.valid && operands.ready;
	assign out_free = !out_valid_q || result.ready;
	assign finish   = (state_q == ST_CHECK) && (a_q == '0) && out_free;

	assign operands.ready = (state_q == ST_IDLE);

	always_comb begin
		div_ctrl.load = (state_q == ST_CHECK) && (a_q != '0);
		div_ctrl.run  = (state_q == ST_DIV);
	end

	eeg_div_unit #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_div (
		.clk     (clk),
		.ctrl    (div_ctrl),
		.dividend(g_q),
		.divisor (a_q),
		.coef_x  (nx_q),
		.coef_y  (ny_q),
		.rem     (div_rem),
		.prod_x  (div_prod_x),
		.prod_y  (div_prod_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (a_q != '0) state_q <= ST_DIV;
					else if (out_free) state_q <= ST_IDLE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_CHECK;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Remainder sequence registers
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q  <= operands.first_value;
			g_q  <= operands.second_value;
			cx_q <= '0;
			cy_q <= (OPERAND_WIDTH + 1)'(1);
			nx_q <= (OPERAND_WIDTH + 1)'(1);
			ny_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			g_q  <= a_q;
			a_q  <= div_rem;
			cx_q <= nx_q;
			cy_q <= ny_q;
			nx_q <= cx_q - div_prod_x;
			ny_q <= cy_q - div_prod_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_x_q <= cx_q;
			out_y_q <= cy_q;
			out_g_q <= g_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.coefficient_a    = out_x_q;
	assign result.coefficient_b    = out_y_q;
	assign result.greatest_divisor = out_g_q;

	// The remainder stays below the divisor throughout a division
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_rem < a_q))
		else $error("divider remainder not below divisor");

	// After each Euclid step the remainder is strictly below the previous divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (a_q < g_q))
		else $error("remainder sequence did not shrink");

	// A completed item lands in the output register and frees the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("finished result not registered");

	// Divisions always start with a clean bit count
	assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.load |=> (cnt_q == '0))
		else $error("bit counter not cleared at division start");

endmodule

[tb/tb_extended_euclid_gcd.sv]
// Self-checking testbench for the extended Euclid GCD block.
`timescale 1ns / 100ps

module tb_extended_euclid_gcd;

	localparam int OPW          = 32;
	localparam int HOLD_CYCLES  = 3000;   // long receiver hold-off in the backpressure phase
	localparam int DRAIN_CYCLES = 1700;   // about one worst-case request (46 steps)
	localparam int STALL_LIMIT  = 20000;  // cycles with no handshake before giving up

	typedef struct {
		logic [OPW-1:0] first_op;
		logic [OPW-1:0] second_op;
	} operand_pair_t;

	typedef struct {
		logic signed [OPW:0] coef_x;
		logic signed [OPW:0] coef_y;
		logic [OPW-1:0]      divisor;
	} bezout_t;

	logic clk;
	logic arst_n;

	eeg_in_if  #(.OPERAND_WIDTH(OPW)) operands_if ();
	eeg_out_if #(.OPERAND_WIDTH(OPW)) result_if ();

	extended_euclid_gcd #(.OPERAND_WIDTH(OPW)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.result   (result_if)
	);

	operand_pair_t pending_operands[$];
	bezout_t       expected_bezout[$];

	int  src_idle_pct;
	int  sink_stall_pct;
	bit  hold_req;
	int  hold_count;
	bit  request_taken;
	int  mismatches;
	int  quiet_cycles;

	// Remainder sequence with coefficient tracking, 64-bit wrapping arithmetic
	function automatic bezout_t predict_bezout(logic [OPW-1:0] a_in, logic [OPW-1:0] b_in);
		logic [63:0] rem_a, rem_g, cur_x, cur_y, nxt_x, nxt_y, quo, rem, tmp_x, tmp_y;
		bezout_t res;
		rem_a = 64'(a_in);
		rem_g = 64'(b_in);
		cur_x = 64'd0;
		cur_y = 64'd1;
		nxt_x = 64'd1;
		nxt_y = 64'd0;
		while (rem_a != 64'd0) begin
			quo   = rem_g / rem_a;
			rem   = rem_g % rem_a;
			tmp_x = cur_x - nxt_x * quo;
			tmp_y = cur_y - nxt_y * quo;
			cur_x = nxt_x;
			cur_y = nxt_y;
			nxt_x = tmp_x;
			nxt_y = tmp_y;
			rem_g = rem_a;
			rem_a = rem;
		end
		res.coef_x  = cur_x[OPW:0];
		res.coef_y  = cur_y[OPW:0];
		res.divisor = rem_g[OPW-1:0];
		return res;
	endfunction

	// Random operand of a random bit length in 1..max_bits
	function automatic logic [OPW-1:0] rand_operand(int unsigned max_bits);
		int unsigned nbits;
		logic [63:0] raw;
		logic [63:0] mask;
		nbits = $urandom_range(max_bits, 1);
		raw   = {$urandom, $urandom};
		mask  = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 64'd1);
		return OPW'(raw & mask);
	endfunction

	// Consecutive Fibonacci numbers (F(n+1), F(n)): the longest remainder chains
	function automatic operand_pair_t fib_pair(int unsigned n);
		logic [63:0] lo, hi, tmp;
		operand_pair_t p;
		lo = 64'd0;
		hi = 64'd1;
		for (int i = 0; i < n; i++) begin
			tmp = lo + hi;
			lo  = hi;
			hi  = tmp;
		end
		p.first_op  = OPW'(hi);
		p.second_op = OPW'(lo);
		return p;
	endfunction

	function automatic operand_pair_t rand_pair(int unsigned max_bits);
		operand_pair_t p;
		int unsigned   kind;
		logic [63:0]   prod;
		kind        = $urandom_range(99, 0);
		p.first_op  = rand_operand(max_bits);
		p.second_op = rand_operand(max_bits);
		if (kind < 4) begin
			p.first_op = '0;
		end else if (kind < 8) begin
			p.second_op = '0;
		end else if (kind < 12) begin
			p.second_op = p.first_op;
		end else if (kind < 18) begin
			prod = 64'(rand_operand((max_bits > 20) ? 20 : max_bits)) * $urandom_range(1000, 1);
			p.first_op  = OPW'(prod >> 0) == '0 ? p.first_op : p.first_op;
			p.second_op = OPW'(prod);
			p.first_op  = (prod == 64'd0) ? p.first_op : OPW'(prod / $urandom_range(3, 1));
		end else if (kind < 22) begin
			p = fib_pair($urandom_range(46, 1));
			if ($urandom_range(1, 0))
				p = '{p.second_op, p.first_op};
		end else if (kind < 30) begin
			p.first_op  = OPW'($urandom);
			p.second_op = OPW'($urandom);
		end
		return p;
	endfunction

	task automatic add_pair(logic [OPW-1:0] a, logic [OPW-1:0] b);
		pending_operands.push_back('{a, b});
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_operands.size() != 0 || operands_if.valid ||
			expected_bezout.size() != 0);
		@(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count, int unsigned max_bits);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			pending_operands.push_back(rand_pair(max_bits));
		wait_drained();
	endtask

	initial begin
		clk                       = 1'b0;
		operands_if.valid         = 1'b0;
		operands_if.first_value   = '0;
		operands_if.second_value  = '0;
		result_if.ready           = 1'b0;
		forever #5 clk = ~clk;
	end

	// Request driver
	always @(negedge clk or negedge arst_n) begin
		operand_pair_t next_pair;
		if (!arst_n) begin
			operands_if.valid        <= 1'b0;
			operands_if.first_value  <= '0;
			operands_if.second_value <= '0;
		end else if (!operands_if.valid || request_taken) begin
			if (pending_operands.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
				next_pair = pending_operands.pop_front();
				operands_if.valid        <= 1'b1;
				operands_if.first_value  <= next_pair.first_op;
				operands_if.second_value <= next_pair.second_op;
			end else begin
				operands_if.valid <= 1'b0;
			end
		end
	end

	// Result ready, with the long hold-off counted here
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_count      <= 0;
		end else if (hold_req && hold_count < HOLD_CYCLES) begin
			result_if.ready <= 1'b0;
			hold_count      <= hold_count + 1;
		end else begin
			result_if.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
		end
	end

	// Accepted requests: predict the result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_taken <= 1'b0;
		end else begin
			request_taken <= operands_if.valid && operands_if.ready;
			if (operands_if.valid && operands_if.ready)
				expected_bezout.push_back(predict_bezout(operands_if.first_value,
					operands_if.second_value));
		end
	end

	// Accepted results: compare with the oldest prediction
	always @(posedge clk) begin
		bezout_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_bezout.size() == 0) begin
				mismatches++;
				$display("%0t ERROR unexpected result x=%0d y=%0d g=%0d", $realtime,
					result_if.coefficient_a, result_if.coefficient_b,
					result_if.greatest_divisor);
			end else begin
				want = expected_bezout.pop_front();
				if (result_if.coefficient_a !== want.coef_x) begin
					mismatches++;
					$display("%0t ERROR coefficient_a expected %0d got %0d", $realtime,
						want.coef_x, result_if.coefficient_a);
				end
				if (result_if.coefficient_b !== want.coef_y) begin
					mismatches++;
					$display("%0t ERROR coefficient_b expected %0d got %0d", $realtime,
						want.coef_y, result_if.coefficient_b);
				end
				if (result_if.greatest_divisor !== want.divisor) begin
					mismatches++;
					$display("%0t ERROR greatest_divisor expected %0d got %0d", $realtime,
						want.divisor, result_if.greatest_divisor);
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operands_if.valid && operands_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t ERROR no handshake for %0d cycles", $realtime, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_req       = 1'b0;
		mismatches     = 0;
		quiet_cycles   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		#2 arst_n = 1'b1;
		@(posedge clk);

		// zero operands, extremes, worst-case chains, coprime and divisible pairs
		add_pair('0, '0);
		add_pair('0, 32'd5);
		add_pair('0, '1);
		add_pair(32'd7, '0);
		add_pair('1, '0);
		add_pair(32'd1, 32'd1);
		add_pair('1, '1);
		add_pair('1, 32'hFFFF_FFFE);
		add_pair(32'hFFFF_FFFE, '1);
		add_pair(32'd2971215073, 32'd1836311903);
		add_pair(32'd1836311903, 32'd2971215073);
		add_pair(32'd12, 32'd18);
		add_pair(32'd18, 32'd12);
		add_pair(32'd1, '1);
		add_pair('1, 32'd1);
		add_pair(32'h8000_0000, '1);
		add_pair(32'hAAAA_AAAA, 32'h5555_5555);
		add_pair(32'h5555_5555, 32'hAAAA_AAAA);
		add_pair(32'h0001_0000, 32'h8000_0000);
		add_pair(32'd4294967291, 32'd4294967279);
		add_pair(32'd6, 32'd3_000_000_006);
		run_phase(0, 0, 400, OPW);
		run_phase(69, 0, 400, OPW);
		run_phase(0, 69, 400, OPW);
		run_phase(29, 29, 400, OPW);

		// backpressure: receiver holds off while short requests keep coming
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_req       = 1'b1;
		for (int i = 0; i < 30; i++)
			pending_operands.push_back(rand_pair(10));
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bezout.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/eeg_pkg.sv
hdl/eeg_if.sv
hdl/eeg_div_unit.sv
hdl/extended_euclid_gcd.sv
tb/tb_extended_euclid_gcd.sv
